/* hdl/slcg_pkg.sv */
// Shared types and constants for the complex-grid SOR solver.
package slcg_pkg;

    localparam int FIELD_BITS = 24;
    localparam int FRAC_Q14   = 14;
    localparam int ONE_Q14    = 16384;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SWEEP = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] REG_OMEGA = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic [7:0]               row;
        logic [7:0]               col;
        logic signed [23:0]       load_re;
        logic signed [23:0]       load_im;
        logic [9:0]               sweep_count;
    } req_t;

    typedef struct packed {
        logic signed [23:0] read_re;
        logic signed [23:0] read_im;
        logic [1:0]         done_op;
    } rsp_t;

endpackage

/* hdl/sor_laplace_complex_grid_top.sv */
// Top level of the complex-grid SOR Laplace solver.
//  channel | direction | handshake        | payload
//  req     | in        | push / full      | req (op,row,col,load_re,load_im,sweep_count)
//  rsp     | out       | pop / empty      | rsp (read_re,read_im,done_op)
//  cfg     | in        | cfg_we           | cfg_index, cfg_data
// Loads and no-op requests pass the engine through S_RSP and S_WAIT; reads inside
// the grid go through S_RD first for the registered RAM read. A sweep request runs
// S_FETCH, S_MUL and S_WB for each interior cell per sweep, paced by the single RAM
// port (six fetch phases for five stencil reads, one multiply stage, one write-back),
// then S_RSP and S_WAIT. A two-entry request queue keeps accepting while the
// engine works. Reset clears control only; the cell RAM is undefined until
// loaded. A stalled result holds the engine until popped.
module sor_laplace_complex_grid_top
    import slcg_pkg::*;
#(
    parameter int GRID_COLS  = 256,
    parameter int GRID_ROWS  = 256,
    parameter int VALUE_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  req_t       req,
    output logic       empty,
    input  logic       pop,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [14:0] cfg_data
);
    logic        q_valid, q_take, rsp_valid;
    req_t        q_req;
    logic [14:0] omega_reg;
    logic [8:0]  cols_reg, rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= 15'd27853;
            cols_reg  <= 9'd256;
            rows_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OMEGA: omega_reg <= cfg_data;
                REG_COLS:  cols_reg  <= cfg_data[8:0];
                REG_ROWS:  rows_reg  <= cfg_data[8:0];
                default:   ;
            endcase
        end
    end

    slcg_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .req(req), .full(full),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
    );

    slcg_back #(
        .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
        .omega(omega_reg), .cols_in_use(cols_reg), .rows_in_use(rows_reg),
        .rsp_valid(rsp_valid), .rsp(rsp), .rsp_ready(pop)
    );

    assign empty = ~rsp_valid;

    // A taken request must have been waiting in the queue.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("take from empty queue");
    // Result stays presented until popped.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
    // Engine never takes a request while a result waits.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !q_take) else $error("take while result pending");
endmodule

/* hdl/slcg_ram.sv */
// Generic single-port RAM with registered read.
module slcg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* hdl/slcg_front.sv */
// Request queue between the input port and the execution engine.
module slcg_front
    import slcg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t req,
    output logic full,
    output logic q_valid,
    output req_t q_req,
    input  logic q_take
);
    req_t       buf_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            buf_reg[wp_reg] <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (q_take && q_valid)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0)
                               - 2'((q_take && q_valid) ? 1 : 0);
        end
    end
endmodule

/* hdl/slcg_back.sv */
// Execution engine: loads, reads and SOR sweeps over the cell RAM.
module slcg_back
    import slcg_pkg::*;
#(
    parameter int GRID_COLS  = 256,
    parameter int GRID_ROWS  = 256,
    parameter int VALUE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  req_t        q_req,
    output logic        q_take,
    input  logic [14:0] omega,
    input  logic [8:0]  cols_in_use,
    input  logic [8:0]  rows_in_use,
    output logic        rsp_valid,
    output rsp_t        rsp,
    input  logic        rsp_ready
);
    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = CW + RW;
    localparam int DW = 2 * VALUE_BITS;
    localparam int XW = (CW > 9 ? CW : 9) + 1;
    localparam int YW = (RW > 9 ? RW : 9) + 1;
    localparam int SW = VALUE_BITS + 3;
    localparam int PW = VALUE_BITS + 20;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_WB    = 7'b0010000,
        S_RSP   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] addr;
    logic          we;
    logic [DW-1:0] wdata, rdata;

    slcg_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    req_t          cur_reg;
    logic [XW-1:0] x_reg, w_eff;
    logic [YW-1:0] y_reg, h_eff;
    logic [9:0]    sw_reg;
    logic [2:0]    ph_reg;
    logic signed [VALUE_BITS-1:0] c_re_reg, c_im_reg;
    logic signed [SW-1:0]         s_re_reg, s_im_reg;
    logic signed [PW-1:0]         acc_re_reg, acc_im_reg;
    logic signed [FIELD_BITS-1:0] out_re_reg, out_im_reg;

    always_comb
    begin
        w_eff = (XW'(cols_in_use) > XW'(GRID_COLS)) ? XW'(GRID_COLS) : XW'(cols_in_use);
        h_eff = (YW'(rows_in_use) > YW'(GRID_ROWS)) ? YW'(GRID_ROWS) : YW'(rows_in_use);
    end

    function automatic logic signed [VALUE_BITS-1:0] sat_v(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi, lo;
        hi = PW'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
        lo = -hi - PW'(1);
        if (v > hi)      return hi[VALUE_BITS-1:0];
        else if (v < lo) return lo[VALUE_BITS-1:0];
        else             return v[VALUE_BITS-1:0];
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] sat_f(
        input logic signed [VALUE_BITS-1:0] v);
        logic signed [PW-1:0] e;
        e = PW'(v);
        if (e > PW'(8388607))       return 24'sh7FFFFF;
        else if (e < -PW'(8388608)) return 24'sh800000;
        else                        return e[FIELD_BITS-1:0];
    endfunction

    logic in_grid;
    assign in_grid = (32'(q_req.row) < GRID_ROWS) && (32'(q_req.col) < GRID_COLS);
    logic cur_inside;
    assign cur_inside = (32'(cur_reg.row) < GRID_ROWS) && (32'(cur_reg.col) < GRID_COLS);

    // Stencil address for the current fetch phase: center, up, down, left, right.
    logic [AW-1:0] sten_addr;
    always_comb
    begin
        unique case (ph_reg)
            3'd1:    sten_addr = AW'((y_reg - 1'b1) * GRID_COLS + x_reg);
            3'd2:    sten_addr = AW'((y_reg + 1'b1) * GRID_COLS + x_reg);
            3'd3:    sten_addr = AW'(y_reg * GRID_COLS + x_reg - 1'b1);
            3'd4:    sten_addr = AW'(y_reg * GRID_COLS + x_reg + 1'b1);
            default: sten_addr = AW'(y_reg * GRID_COLS + x_reg);
        endcase
    end

    logic signed [VALUE_BITS-1:0] rd_re, rd_im;
    assign rd_re = rdata[DW-1:VALUE_BITS];
    assign rd_im = rdata[VALUE_BITS-1:0];

    // Signed omega and (1 - omega) in Q2.14; 1 - omega goes negative above 1.0.
    logic signed [15:0] w_s;
    logic signed [16:0] one_m_w;
    assign w_s     = $signed({1'b0, omega});
    assign one_m_w = 17'(ONE_Q14) - 17'(w_s);

    logic signed [VALUE_BITS-1:0] new_re, new_im;
    logic signed [PW-1:0] rnd_re, rnd_im;
    assign rnd_re = (acc_re_reg + PW'(32768)) >>> 16;
    assign rnd_im = (acc_im_reg + PW'(32768)) >>> 16;
    assign new_re = sat_v(rnd_re);
    assign new_im = sat_v(rnd_im);

    logic signed [PW-1:0] ld_re, ld_im;
    assign ld_re = PW'(cur_reg.load_re);
    assign ld_im = PW'(cur_reg.load_im);

    logic last_x, last_y, last_sw, no_int;
    assign last_x  = (x_reg + 2'd2 >= w_eff);
    assign last_y  = (y_reg + 2'd2 >= h_eff);
    assign last_sw = (sw_reg <= 10'd1);
    assign no_int  = (w_eff < XW'(3)) || (h_eff < YW'(3));

    always_comb
    begin
        state_next = state_reg;
        q_take = 1'b0;
        we = 1'b0;
        addr = sten_addr;
        wdata = {sat_v(ld_re), sat_v(ld_im)};
        unique case (state_reg)
            S_IDLE:
            begin
                addr = AW'(32'(q_req.row) * GRID_COLS + 32'(q_req.col));
                if (q_valid)
                begin
                    q_take = 1'b1;
                    unique case (op_t'(q_req.op))
                        OP_LOAD:  state_next = S_RSP;
                        OP_READ:  state_next = in_grid ? S_RD : S_RSP;
                        OP_SWEEP: state_next = (q_req.sweep_count == 10'd0) ? S_RSP
                                             : S_FETCH;
                        default:  state_next = S_RSP;
                    endcase
                end
            end
            S_RD:
                state_next = S_RSP;
            S_FETCH:
            begin
                if (no_int)
                    state_next = S_RSP;
                else if (ph_reg == 3'd5)
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_WB;
            S_WB:
            begin
                we = 1'b1;
                addr = AW'(y_reg * GRID_COLS + x_reg);
                wdata = {new_re, new_im};
                state_next = (last_x && last_y && last_sw) ? S_RSP : S_FETCH;
            end
            S_RSP:
            begin
                if (cur_reg.op == OP_LOAD && cur_inside)
                begin
                    we = 1'b1;
                    addr = AW'(32'(cur_reg.row) * GRID_COLS + 32'(cur_reg.col));
                end
                state_next = S_WAIT;
            end
            S_WAIT:
                if (rsp_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign rsp_valid   = (state_reg == S_WAIT);
    assign rsp.read_re = out_re_reg;
    assign rsp.read_im = out_im_reg;
    assign rsp.done_op = cur_reg.op;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            cur_reg    <= q_req;
            sw_reg     <= q_req.sweep_count;
            x_reg      <= XW'(1);
            y_reg      <= YW'(1);
            out_re_reg <= '0;
            out_im_reg <= '0;
        end
        if (state_reg == S_RD)
        begin
            out_re_reg <= sat_f(rd_re);
            out_im_reg <= sat_f(rd_im);
        end
        // Read data arrives in the cycle after the address; phase k-1 data lands in phase k.
        if (state_reg == S_FETCH)
        begin
            unique case (ph_reg)
                3'd1:
                begin
                    c_re_reg <= rd_re;
                    c_im_reg <= rd_im;
                end
                3'd2:
                begin
                    s_re_reg <= SW'(rd_re);
                    s_im_reg <= SW'(rd_im);
                end
                3'd0:
                begin
                end
                default:
                begin
                    s_re_reg <= s_re_reg + SW'(rd_re);
                    s_im_reg <= s_im_reg + SW'(rd_im);
                end
            endcase
        end
        // acc = 4*c*(1 - omega) + omega*sum, all in Q14 units.
        if (state_reg == S_MUL)
        begin
            acc_re_reg <= (PW'(c_re_reg * one_m_w) <<< 2) + PW'(s_re_reg * w_s);
            acc_im_reg <= (PW'(c_im_reg * one_m_w) <<< 2) + PW'(s_im_reg * w_s);
        end
        if (state_reg == S_WB)
        begin
            if (last_x)
            begin
                x_reg <= XW'(1);
                if (last_y)
                begin
                    y_reg  <= YW'(1);
                    sw_reg <= sw_reg - 10'd1;
                end
                else
                    y_reg <= y_reg + 1'b1;
            end
            else
                x_reg <= x_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FETCH && ph_reg != 3'd5)
                ph_reg <= ph_reg + 3'd1;
            else
                ph_reg <= 3'd0;
        end
    end
endmodule

/* verif/tb.sv */
// Self-checking testbench for the complex-grid SOR Laplace solver.
`timescale 1ns / 100ps

module tb;
    import slcg_pkg::*;

    localparam int GRID_N     = 256;
    localparam int RANDOM_REQ = 2000;
    localparam int SETTLE     = 40;        // cycles after the last result before a reg write
    localparam int HOLD_LEN   = 400;       // long receiver hold-off
    localparam longint LIMIT  = 4000000;   // cycle budget for the whole run

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    req_t        req = '0;
    logic        empty;
    logic        pop = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_OMEGA;
    logic [14:0] cfg_data = '0;

    always #5 clk = ~clk;

    sor_laplace_complex_grid_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Solver image kept by the testbench: cell values, which cells have
    // been loaded, and the three registers.
    // ------------------------------------------------------------------
    logic signed [23:0] grid_re [0:GRID_N*GRID_N-1];
    logic signed [23:0] grid_im [0:GRID_N*GRID_N-1];
    bit                 loaded  [0:GRID_N*GRID_N-1];
    logic [14:0]        omega_q = 15'd27853;
    logic [8:0]         cols_q  = 9'd256;
    logic [8:0]         rows_q  = 9'd256;

    rsp_t   expected_rsp [$];
    int     mismatches = 0;
    int     req_sent = 0;
    int     sweeps_sent = 0;
    int     reads_sent = 0;
    int     rsp_seen = 0;
    longint cycles = 0;

    // idling knobs, percent of cycles
    int     send_gap_pct = 0;
    int     pop_stall_pct = 0;

    // receiver hold-off, counted in the receiver's own process
    logic   start_hold = 1'b0;
    int     hold_left = 0;

    function automatic int cols_eff();
        return (cols_q > GRID_N) ? GRID_N : int'(cols_q);
    endfunction

    function automatic int rows_eff();
        return (rows_q > GRID_N) ? GRID_N : int'(rows_q);
    endfunction

    // One stencil update: acc = 4*c*(1-w) + w*sum, scale by 2^-16, round half up,
    // saturate to 24 bits.
    function automatic logic signed [23:0] relaxed(longint c, longint up, longint dn,
                                                   longint lf, longint rt);
        longint acc;
        longint w;
        w   = longint'(omega_q);
        acc = 4 * c * (64'sd16384 - w) + w * (up + dn + lf + rt);
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > 64'sd8388607)
            acc = 64'sd8388607;
        else if (acc < -64'sd8388608)
            acc = -64'sd8388608;
        return acc[23:0];
    endfunction

    function automatic void relax_grid();
        int w;
        int h;
        int i;
        w = cols_eff();
        h = rows_eff();
        if (w < 3 || h < 3)
            return;
        for (int y = 1; y + 1 < h; y++)
            for (int x = 1; x + 1 < w; x++)
            begin
                i = y * GRID_N + x;
                grid_re[i] = relaxed(grid_re[i], grid_re[i-GRID_N], grid_re[i+GRID_N],
                                     grid_re[i-1], grid_re[i+1]);
                grid_im[i] = relaxed(grid_im[i], grid_im[i-GRID_N], grid_im[i+GRID_N],
                                     grid_im[i-1], grid_im[i+1]);
            end
    endfunction

    // Applies one accepted request to the image and queues the expected result.
    function automatic void predict_rsp(req_t r);
        rsp_t e;
        int   i;
        e = '0;
        e.done_op = r.op;
        i = int'(r.row) * GRID_N + int'(r.col);
        case (op_t'(r.op))
            OP_LOAD:
            begin
                grid_re[i] = r.load_re;
                grid_im[i] = r.load_im;
                loaded[i]  = 1'b1;
            end
            OP_SWEEP:
            begin
                for (int k = 0; k < int'(r.sweep_count); k++)
                    relax_grid();
            end
            OP_READ:
            begin
                e.read_re = grid_re[i];
                e.read_im = grid_im[i];
            end
            default: ;
        endcase
        expected_rsp.push_back(e);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one request and waits for the handshake. push is left high after
    // acceptance unless a gap is rolled, so back-to-back requests keep it up.
    task automatic send_req(req_t r);
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
        predict_rsp(r);
        req_sent++;
        if (op_t'(r.op) == OP_SWEEP)
            sweeps_sent++;
        if (op_t'(r.op) == OP_READ)
            reads_sent++;
        if ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    // Drops push and waits for every outstanding result, then lets the
    // engine settle.
    task automatic drain();
        push <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write, only called with the block drained.
    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OMEGA: omega_q = val;
            REG_COLS:  cols_q  = val[8:0];
            REG_ROWS:  rows_q  = val[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic req_t make_req(op_t op, int row, int col,
                                      logic [23:0] re, logic [23:0] im, int cnt);
        req_t r;
        r.op          = op;
        r.row         = row[7:0];
        r.col         = col[7:0];
        r.load_re     = re;
        r.load_im     = im;
        r.sweep_count = cnt[9:0];
        return r;
    endfunction

    function automatic logic [23:0] rand_value();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'(int'($urandom_range(2097152)) - 1048576); // within +-1.0
            default: return 24'($urandom);
        endcase
    endfunction

    // Loads every cell of the active grid so that sweeps and reads there stay
    // on written cells.
    task automatic fill_grid();
        for (int y = 0; y < rows_eff(); y++)
            for (int x = 0; x < cols_eff(); x++)
                send_req(make_req(OP_LOAD, y, x, rand_value(), rand_value(),
                                  $urandom_range(1023)));
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, hold-off, and the scoreboard check.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (start_hold)
            hold_left <= HOLD_LEN;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;

        pop <= !start_hold && hold_left <= 1 && ($urandom_range(99) >= pop_stall_pct);

        if (rst_n && pop && !empty)
        begin
            rsp_seen++;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result read_re=%h read_im=%h done_op=%0d",
                         $time, rsp.read_re, rsp.read_im, rsp.done_op);
                mismatches++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsp.pop_front();
                if (rsp.read_re !== e.read_re)
                begin
                    $display("%0t: read_re expected %h actual %h", $time, e.read_re,
                             rsp.read_re);
                    mismatches++;
                end
                if (rsp.read_im !== e.read_im)
                begin
                    $display("%0t: read_im expected %h actual %h", $time, e.read_im,
                             rsp.read_im);
                    mismatches++;
                end
                if (rsp.done_op !== e.done_op)
                begin
                    $display("%0t: done_op expected %0d actual %0d", $time, e.done_op,
                             rsp.done_op);
                    mismatches++;
                end
            end
        end
    end

    // Global watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: run exceeded the cycle budget", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Corners, field extremes, no-op, zero sweep count, grids with no
    // interior, and both ends of omega on the smallest grid.
    task automatic test_directed();
        send_req(make_req(OP_LOAD, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0));
        send_req(make_req(OP_LOAD, 255, 255, 24'h800000, 24'h800000, 1023));
        send_req(make_req(OP_LOAD, 0, 255, 24'h000000, 24'hFFFFFF, 0));
        send_req(make_req(OP_LOAD, 255, 0, 24'h555555, 24'hAAAAAA, 0));
        send_req(make_req(OP_READ, 0, 0, 0, 0, 0));
        send_req(make_req(OP_READ, 255, 255, 24'hFFFFFF, 24'hFFFFFF, 1023));
        send_req(make_req(OP_READ, 0, 255, 0, 0, 0));
        send_req(make_req(OP_READ, 255, 0, 0, 0, 0));
        send_req(make_req(OP_NONE, 255, 255, 24'hFFFFFF, 24'hFFFFFF, 1023));
        send_req(make_req(OP_NONE, 0, 0, 0, 0, 0));
        // zero count on the full 256x256 grid runs nothing
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 0));
        drain();

        // no interior: sweeps leave everything alone
        write_reg(REG_COLS, 15'd0);
        write_reg(REG_ROWS, 15'd256);
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 3));
        drain();
        write_reg(REG_COLS, 15'd256);
        write_reg(REG_ROWS, 15'd2);
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 5));
        send_req(make_req(OP_READ, 0, 0, 0, 0, 0));
        drain();

        // 3x3 grid, one interior cell: omega 0 keeps it, max count
        write_reg(REG_OMEGA, 15'd0);
        write_reg(REG_ROWS, 15'd3);
        write_reg(REG_COLS, 15'd3);
        fill_grid();
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 1023));
        send_req(make_req(OP_READ, 1, 1, 0, 0, 0));
        drain();
        write_reg(REG_OMEGA, 15'd32767);
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 1));
        send_req(make_req(OP_READ, 1, 1, 0, 0, 0));
        drain();
    endtask

    // Long hold-off on the result side while requests keep coming, then a
    // full pause on the request side.
    task automatic test_backpressure();
        send_gap_pct  = 0;
        pop_stall_pct = 0;
        start_hold <= 1'b1;
        @(posedge clk);
        start_hold <= 1'b0;
        for (int n = 0; n < 30; n++)
            send_req(make_req(OP_READ, $urandom_range(rows_eff() - 1),
                              $urandom_range(cols_eff() - 1), 0, 0, 0));
        drain();
    endtask

    // Widest grid (column count clamped) over three rows.
    task automatic test_wide_grid();
        write_reg(REG_OMEGA, 15'($urandom_range(32767)));
        write_reg(REG_ROWS, 15'd3);
        write_reg(REG_COLS, 15'd511);
        fill_grid();
        send_req(make_req(OP_SWEEP, 0, 0, 0, 0, 2));
        for (int n = 0; n < 12; n++)
            send_req(make_req(OP_READ, $urandom_range(2), $urandom_range(255), 0, 0, 0));
        drain();
    endtask

    // Phases of random traffic, mostly on small grids. Each phase picks registers,
    // loads the whole grid, then mixes loads, reads, sweeps and no-ops.
    task automatic test_random();
        int phase;
        int pick;
        int om;
        phase = 0;
        while (req_sent < RANDOM_REQ)
        begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_gap_pct = 64; pop_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  pop_stall_pct = 64; end
                default: begin send_gap_pct = 23; pop_stall_pct = 23; end
            endcase
            pick = $urandom_range(9);
            om = (pick == 0) ? 0 : (pick == 1) ? 32767 : (pick < 6) ?
                 $urandom_range(32767) : $urandom_range(20000, 30000);
            write_reg(REG_OMEGA, 15'(om));
            write_reg(REG_COLS, 15'((phase % 7 == 6) ? 256 : $urandom_range(8, 3)));
            write_reg(REG_ROWS, 15'($urandom_range(8, 3)));
            if (phase % 7 == 6)
                write_reg(REG_ROWS, 15'd3);
            fill_grid();
            for (int n = 0; n < 60; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send_req(make_req(OP_READ, $urandom_range(rows_eff() - 1),
                                      $urandom_range(cols_eff() - 1),
                                      24'($urandom), 24'($urandom), $urandom_range(1023)));
                else if (pick < 55)
                    send_req(make_req(OP_LOAD, $urandom_range(rows_eff() - 1),
                                      $urandom_range(cols_eff() - 1),
                                      rand_value(), rand_value(), $urandom_range(1023)));
                else if (pick < 65)
                    send_req(make_req(OP_LOAD, $urandom_range(255), $urandom_range(255),
                                      rand_value(), rand_value(), $urandom_range(1023)));
                else if (pick < 80)
                    send_req(make_req(OP_SWEEP, $urandom_range(255), $urandom_range(255),
                                      24'($urandom), 24'($urandom),
                                      (pick == 79) ? $urandom_range(12) : $urandom_range(3)));
                else if (pick < 85)
                    send_req(make_req(OP_NONE, $urandom_range(255), $urandom_range(255),
                                      24'($urandom), 24'($urandom), $urandom_range(1023)));
                else
                    // reads in column 0 of a row inside the grid, already loaded
                    send_req(make_req(OP_READ, $urandom_range(rows_eff() - 1), 0, 0, 0, 0));
            end
            drain();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_backpressure();
        test_wide_grid();
        test_random();
        test_backpressure();
        drain();

        $display("Covered %0d requests (%0d sweeps, %0d reads), %0d results checked,",
                 req_sent, sweeps_sent, reads_sent, rsp_seen);
        $display("over omega/grid settings from degenerate to widest, with stalls.");
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hdl/slcg_pkg.sv
hdl/slcg_ram.sv
hdl/slcg_front.sv
hdl/slcg_back.sv
hdl/sor_laplace_complex_grid_top.sv
verif/tb.sv
